// ===== sv/vca_pkg.sv =====
`default_nettype none

package vca_pkg;

    // Command opcodes; code seven is unused and leaves the table alone.
    typedef enum logic [2:0] {
        OP_PLAY     = 3'd0,
        OP_STOP     = 3'd1,
        OP_PAUSE    = 3'd2,
        OP_RESUME   = 3'd3,
        OP_QUERY    = 3'd4,
        OP_DONE     = 3'd5,
        OP_STOP_ALL = 3'd6
    } t_vca_op;

    localparam logic [1:0] STS_OK          = 2'd0;
    localparam logic [1:0] STS_NO_HANDLE   = 2'd1;
    localparam logic [1:0] STS_WRONG_STATE = 2'd2;

    localparam logic [1:0] KIND_FREE    = 2'd0;
    localparam logic [1:0] KIND_SAME    = 2'd1;
    localparam logic [1:0] KIND_LOOPING = 2'd2;
    localparam logic [1:0] KIND_OLDEST  = 2'd3;

    localparam logic [1:0] VS_STOPPED = 2'd0;
    localparam logic [1:0] VS_PLAYING = 2'd1;
    localparam logic [1:0] VS_PAUSED  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_FINISH = 2'd2
    } t_vca_state;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  sound_id;
        logic        loop_flag;
        logic [31:0] voice_handle;
        logic [2:0]  done_channel;
    } t_vca_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] new_handle;
        logic [2:0]  chosen_channel;
        logic [1:0]  steal_kind;
        logic [31:0] stolen_handle;
        logic [1:0]  voice_state;
    } t_vca_rsp;

    // Sequencer to scan unit: clear the trackers, or take one table entry.
    typedef struct packed {
        logic clr;
        logic vld;
    } t_vca_scan_ctl;

    // Scan unit to sequencer: which searches have a candidate.
    typedef struct packed {
        logic free;
        logic same;
        logic loops;
        logic any;
        logic hit;
    } t_vca_found;

endpackage

`default_nettype wire

// ===== sv/vca_cmd_if.sv =====
`default_nettype none

interface vca_cmd_if;
    logic               valid;
    logic               ready;
    vca_pkg::t_vca_cmd  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/vca_rsp_if.sv =====
`default_nettype none

interface vca_rsp_if;
    logic               valid;
    logic               ready;
    vca_pkg::t_vca_rsp  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/vca_scan.sv =====
`default_nettype none

module vca_scan #(
    parameter int NUM_CHANNELS  = 8,
    parameter int SOUND_ID_BITS = 8,
    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire vca_pkg::t_vca_scan_ctl     i_ctl,
    input  wire logic [AW-1:0]              i_ch,
    input  wire logic                       i_busy,
    input  wire logic [31:0]                i_handle,
    input  wire logic [SOUND_ID_BITS-1:0]   i_sound,
    input  wire logic                       i_looping,
    input  wire logic                       i_paused,
    input  wire logic [31:0]                i_counter,
    input  wire logic [SOUND_ID_BITS-1:0]   i_snd,
    input  wire logic [31:0]                i_key,
    output vca_pkg::t_vca_found             o_found,
    output logic [AW-1:0]                   o_free_ch,
    output logic [AW-1:0]                   o_same_ch,
    output logic [AW-1:0]                   o_loop_ch,
    output logic [AW-1:0]                   o_any_ch,
    output logic [31:0]                     o_same_age,
    output logic [31:0]                     o_loop_age,
    output logic [31:0]                     o_any_age,
    output logic [AW-1:0]                   o_hit_ch,
    output logic                            o_hit_paused,
    output logic                            o_hit_looping,
    output logic [SOUND_ID_BITS-1:0]        o_hit_sound
);

    vca_pkg::t_vca_found        r_found;
    logic [AW-1:0]              r_free_ch;
    logic [AW-1:0]              r_same_ch;
    logic [AW-1:0]              r_loop_ch;
    logic [AW-1:0]              r_any_ch;
    logic [31:0]                r_same_age;
    logic [31:0]                r_loop_age;
    logic [31:0]                r_any_age;
    logic [AW-1:0]              r_hit_ch;
    logic                       r_hit_paused;
    logic                       r_hit_looping;
    logic [SOUND_ID_BITS-1:0]   r_hit_sound;

    logic [31:0] w_age;

    // Shared age subtractor; strict compares keep the lowest channel on ties.
    assign w_age = i_counter - i_handle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= '0;
        end else if (i_ctl.clr) begin
            r_found <= '0;
        end else if (i_ctl.vld) begin
            if (!i_busy && !r_found.free) begin
                r_found.free <= 1'b1;
                r_free_ch    <= i_ch;
            end
            if (i_busy) begin
                if ((i_sound == i_snd) && (!r_found.same || (w_age > r_same_age))) begin
                    r_found.same <= 1'b1;
                    r_same_ch    <= i_ch;
                    r_same_age   <= w_age;
                end
                if (i_looping && (!r_found.loops || (w_age > r_loop_age))) begin
                    r_found.loops <= 1'b1;
                    r_loop_ch     <= i_ch;
                    r_loop_age    <= w_age;
                end
                if (!r_found.any || (w_age > r_any_age)) begin
                    r_found.any <= 1'b1;
                    r_any_ch    <= i_ch;
                    r_any_age   <= w_age;
                end
                if (!r_found.hit && (i_key != 32'd0) && (i_handle == i_key)) begin
                    r_found.hit   <= 1'b1;
                    r_hit_ch      <= i_ch;
                    r_hit_paused  <= i_paused;
                    r_hit_looping <= i_looping;
                    r_hit_sound   <= i_sound;
                end
            end
        end
    end

    assign o_found       = r_found;
    assign o_free_ch     = r_free_ch;
    assign o_same_ch     = r_same_ch;
    assign o_loop_ch     = r_loop_ch;
    assign o_any_ch      = r_any_ch;
    assign o_same_age    = r_same_age;
    assign o_loop_age    = r_loop_age;
    assign o_any_age     = r_any_age;
    assign o_hit_ch      = r_hit_ch;
    assign o_hit_paused  = r_hit_paused;
    assign o_hit_looping = r_hit_looping;
    assign o_hit_sound   = r_hit_sound;

endmodule

`default_nettype wire

// ===== sv/voice_channel_allocator_core.sv =====
// Voice channel allocator.
// Commands arrive as beats on i_cmd (valid/ready); each command yields exactly
// one response beat on o_rsp. The channel table lives in a small RAM (handle,
// sound, loop and pause per channel) with busy bits in flip-flops.
// Play, stop, pause, resume and query walk the table one channel per cycle
// through a single RAM read port and a shared age subtractor: the command is
// taken, the walk reads every channel in turn, and a finish cycle commits the
// table update and loads the response register. Channel done, stop all and
// the unused opcode skip the walk and go straight to the finish cycle.
// i_cmd.ready is high only while the sequencer is idle.
// The response register decouples the two sides: a new command is taken while
// an older response still waits. If the receiver stalls, the finish cycle
// holds and commits nothing until the response register frees up.
// Reset (synchronous, active low) frees every channel at once by clearing the
// busy bits and zeroes the handle counter; the RAM needs no clearing pass.
`default_nettype none

module voice_channel_allocator_core #(
    parameter int NUM_CHANNELS  = 8,
    parameter int SOUND_ID_BITS = 8
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    vca_cmd_if.sink     i_cmd,
    vca_rsp_if.source   o_rsp
);

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SB = SOUND_ID_BITS;
    localparam int EW = 32 + SB + 2;

    // State
    vca_pkg::t_vca_state    r_state, n_state;
    logic [2:0]             r_op;
    logic [SB-1:0]          r_snd;
    logic                   r_loop;
    logic [31:0]            r_key;
    logic [2:0]             r_dc;
    logic [AW:0]            r_idx;
    logic                   r_rd_vld;
    logic [AW-1:0]          r_rd_ch;
    logic [EW-1:0]          r_rd_data;
    logic [NUM_CHANNELS-1:0] r_busy, n_busy;
    logic [31:0]            r_counter, n_counter;
    logic                   r_out_valid;
    vca_pkg::t_vca_rsp      r_out;

    // Table RAM: {paused, looping, sound, handle}
    logic [EW-1:0]          r_mem [NUM_CHANNELS];

    // Control and datapath
    logic                   w_accept;
    logic                   w_scan_op;
    logic                   w_last;
    logic                   w_out_free;
    logic                   w_fire;
    logic [15:0]            w_snd_ext;
    logic [SB-1:0]          w_snd;
    vca_pkg::t_vca_scan_ctl w_scan_ctl;
    vca_pkg::t_vca_found    w_found;
    logic [AW-1:0]          w_free_ch, w_same_ch, w_loop_ch, w_any_ch, w_hit_ch;
    logic [31:0]            w_same_age, w_loop_age, w_any_age;
    logic                   w_hit_paused, w_hit_looping;
    logic [SB-1:0]          w_hit_sound;
    logic [31:0]            w_inc;
    logic [31:0]            w_new_h;
    logic                   w_dc_ok;
    logic [7:0]             w_dc_ext;
    logic [AW-1:0]          w_dc_idx;
    logic [AW-1:0]          w_ch;
    logic [7:0]             w_ch_ext;
    logic [31:0]            w_victim_age;
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [EW-1:0]          w_wdata;
    vca_pkg::t_vca_rsp      w_rsp;

    assign w_snd_ext = {8'd0, i_cmd.data.sound_id};
    assign w_snd     = w_snd_ext[SB-1:0];

    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign w_scan_op  = (i_cmd.data.opcode == vca_pkg::OP_PLAY)
                     || (i_cmd.data.opcode == vca_pkg::OP_STOP)
                     || (i_cmd.data.opcode == vca_pkg::OP_PAUSE)
                     || (i_cmd.data.opcode == vca_pkg::OP_RESUME)
                     || (i_cmd.data.opcode == vca_pkg::OP_QUERY);
    assign w_last     = (r_idx == (AW+1)'(NUM_CHANNELS));
    assign w_out_free = !r_out_valid || o_rsp.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            vca_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = w_scan_op ? vca_pkg::S_SCAN : vca_pkg::S_FINISH;
                end
            end
            vca_pkg::S_SCAN: begin
                if (w_last) begin
                    n_state = vca_pkg::S_FINISH;
                end
            end
            vca_pkg::S_FINISH: begin
                if (w_out_free) begin
                    n_state = vca_pkg::S_IDLE;
                end
            end
            default: n_state = vca_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        i_cmd.ready    = 1'b0;
        w_fire         = 1'b0;
        w_scan_ctl.clr = w_accept;
        w_scan_ctl.vld = r_rd_vld;
        case (r_state)
            vca_pkg::S_IDLE:   i_cmd.ready = 1'b1;
            vca_pkg::S_SCAN:   ;
            vca_pkg::S_FINISH: w_fire = w_out_free;
            default:           ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vca_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Latch the command beat; start the walk at channel zero.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_cmd.data.opcode;
            r_snd  <= w_snd;
            r_loop <= i_cmd.data.loop_flag;
            r_key  <= i_cmd.data.voice_handle;
            r_dc   <= i_cmd.data.done_channel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == vca_pkg::S_SCAN) && !w_last;
            if (w_accept) begin
                r_idx <= '0;
            end else if ((r_state == vca_pkg::S_SCAN) && !w_last) begin
                r_idx <= r_idx + (AW+1)'(1);
            end
        end
    end

    // RAM: one registered read for the walk, one write at commit.
    always_ff @(posedge i_clk) begin
        if ((r_state == vca_pkg::S_SCAN) && !w_last) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
            r_rd_ch   <= r_idx[AW-1:0];
        end
        if (w_fire && w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    vca_scan #(
        .NUM_CHANNELS  (NUM_CHANNELS),
        .SOUND_ID_BITS (SOUND_ID_BITS)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_scan_ctl),
        .i_ch          (r_rd_ch),
        .i_busy        (r_busy[r_rd_ch]),
        .i_handle      (r_rd_data[31:0]),
        .i_sound       (r_rd_data[32 +: SB]),
        .i_looping     (r_rd_data[32+SB]),
        .i_paused      (r_rd_data[33+SB]),
        .i_counter     (r_counter),
        .i_snd         (r_snd),
        .i_key         (r_key),
        .o_found       (w_found),
        .o_free_ch     (w_free_ch),
        .o_same_ch     (w_same_ch),
        .o_loop_ch     (w_loop_ch),
        .o_any_ch      (w_any_ch),
        .o_same_age    (w_same_age),
        .o_loop_age    (w_loop_age),
        .o_any_age     (w_any_age),
        .o_hit_ch      (w_hit_ch),
        .o_hit_paused  (w_hit_paused),
        .o_hit_looping (w_hit_looping),
        .o_hit_sound   (w_hit_sound)
    );

    // Fresh handle: advance the counter, skip zero on wrap.
    assign w_inc   = r_counter + 32'd1;
    assign w_new_h = (w_inc == 32'd0) ? 32'd1 : w_inc;

    // Channel done index; reject channels past the table.
    assign w_dc_ext = {5'd0, r_dc};
    assign w_dc_idx = w_dc_ext[AW-1:0];
    assign w_dc_ok  = ({4'd0, r_dc} < 7'(NUM_CHANNELS));

    // Victim choice for play: free, same sound, looping, then oldest overall.
    always_comb begin
        w_ch         = w_any_ch;
        w_victim_age = w_any_age;
        if (w_found.free) begin
            w_ch         = w_free_ch;
            w_victim_age = 32'd0;
        end else if (w_found.same) begin
            w_ch         = w_same_ch;
            w_victim_age = w_same_age;
        end else if (w_found.loops) begin
            w_ch         = w_loop_ch;
            w_victim_age = w_loop_age;
        end
    end

    assign w_ch_ext = 8'(w_ch);

    // Commit: response, table write and busy/counter update.
    always_comb begin
        w_rsp     = '0;
        w_we      = 1'b0;
        w_waddr   = w_hit_ch;
        w_wdata   = {1'b0, w_hit_looping, w_hit_sound, r_key};
        n_busy    = r_busy;
        n_counter = r_counter;
        case (r_op)
            vca_pkg::OP_PLAY: begin
                if (w_found.free) begin
                    w_rsp.steal_kind = vca_pkg::KIND_FREE;
                end else begin
                    // Stolen handle is recovered from its age and the old counter.
                    w_rsp.stolen_handle = r_counter - w_victim_age;
                    if (w_found.same) begin
                        w_rsp.steal_kind = vca_pkg::KIND_SAME;
                    end else if (w_found.loops) begin
                        w_rsp.steal_kind = vca_pkg::KIND_LOOPING;
                    end else begin
                        w_rsp.steal_kind = vca_pkg::KIND_OLDEST;
                    end
                end
                w_we                 = 1'b1;
                w_waddr              = w_ch;
                w_wdata              = {1'b0, r_loop, r_snd, w_new_h};
                n_busy[w_ch]         = 1'b1;
                n_counter            = w_new_h;
                w_rsp.new_handle     = w_new_h;
                w_rsp.chosen_channel = w_ch_ext[2:0];
            end
            vca_pkg::OP_STOP: begin
                if (w_found.hit) begin
                    n_busy[w_hit_ch] = 1'b0;
                end else begin
                    w_rsp.status = vca_pkg::STS_NO_HANDLE;
                end
            end
            vca_pkg::OP_PAUSE: begin
                if (!w_found.hit) begin
                    w_rsp.status = vca_pkg::STS_NO_HANDLE;
                end else if (w_hit_paused) begin
                    w_rsp.status = vca_pkg::STS_WRONG_STATE;
                end else begin
                    w_we    = 1'b1;
                    w_wdata = {1'b1, w_hit_looping, w_hit_sound, r_key};
                end
            end
            vca_pkg::OP_RESUME: begin
                if (!w_found.hit) begin
                    w_rsp.status = vca_pkg::STS_NO_HANDLE;
                end else if (!w_hit_paused) begin
                    w_rsp.status = vca_pkg::STS_WRONG_STATE;
                end else begin
                    w_we    = 1'b1;
                    w_wdata = {1'b0, w_hit_looping, w_hit_sound, r_key};
                end
            end
            vca_pkg::OP_QUERY: begin
                if (!w_found.hit) begin
                    w_rsp.status      = vca_pkg::STS_NO_HANDLE;
                    w_rsp.voice_state = vca_pkg::VS_STOPPED;
                end else begin
                    w_rsp.voice_state = w_hit_paused ? vca_pkg::VS_PAUSED
                                                     : vca_pkg::VS_PLAYING;
                end
            end
            vca_pkg::OP_DONE: begin
                if (w_dc_ok && r_busy[w_dc_idx]) begin
                    n_busy[w_dc_idx] = 1'b0;
                end else begin
                    w_rsp.status = vca_pkg::STS_NO_HANDLE;
                end
            end
            vca_pkg::OP_STOP_ALL: begin
                n_busy = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= '0;
            r_counter <= 32'd0;
        end else if (w_fire) begin
            r_busy    <= n_busy;
            r_counter <= n_counter;
        end
    end

    // Response register: load at commit, drop once the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_rsp;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // Assertions
    a_play_handle_nonzero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_op == vca_pkg::OP_PLAY)) |=> (r_counter != 32'd0)
    ) else $error("play left the handle counter at zero");

    a_play_marks_busy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_op == vca_pkg::OP_PLAY)) |=> (r_busy != '0)
    ) else $error("play left every channel free");

    a_commit_loads_rsp: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid
    ) else $error("commit did not load the response register");

    a_read_only_in_walk: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == vca_pkg::S_SCAN)
    ) else $error("table read data arrived outside the walk");

endmodule

`default_nettype wire

// ===== sim/tb_voice_channel_allocator_core.sv =====
`default_nettype none

module tb_voice_channel_allocator_core;

    localparam int          NCH          = 8;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          STALL_CYCLES = 400;
    localparam int          TIMEOUT      = 3_000_000;
    localparam logic [2:0]  OP_UNUSED    = 3'd7;
    localparam logic [7:0]  SND_MASK     = 8'hFF;

    // Victim search modes for the steal path.
    localparam int PICK_ANY  = 0;
    localparam int PICK_SAME = 1;
    localparam int PICK_LOOP = 2;

    logic i_clk = 1'b0;
    logic i_rst_n;

    vca_cmd_if cmd_if ();
    vca_rsp_if rsp_if ();

    voice_channel_allocator_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the channel table.
    logic        tbl_busy   [NCH];
    logic [31:0] tbl_handle [NCH];
    logic [7:0]  tbl_sound  [NCH];
    logic        tbl_loop   [NCH];
    logic        tbl_paused [NCH];
    logic [31:0] handle_ctr;

    vca_pkg::t_vca_rsp pending_rsp[$];
    int       errors            = 0;
    int       sender_idle_pct   = 0;
    int       receiver_idle_pct = 0;
    int       stall_left        = 0;
    int       stall_reqs        = 0;
    int       stall_seen        = 0;

    function automatic void clear_chan(input int c);
        tbl_busy[c]   = 1'b0;
        tbl_handle[c] = '0;
        tbl_sound[c]  = '0;
        tbl_loop[c]   = 1'b0;
        tbl_paused[c] = 1'b0;
    endfunction

    function automatic int lookup_handle(input logic [31:0] h);
        if (h == '0) return -1;
        for (int c = 0; c < NCH; c++)
            if (tbl_busy[c] && tbl_handle[c] == h) return c;
        return -1;
    endfunction

    // Oldest voice by wrapped age; ties go to the lower channel.
    function automatic int oldest_voice(input int pick, input logic [7:0] snd);
        int          best;
        logic [31:0] best_age;
        logic [31:0] age;
        best     = -1;
        best_age = '0;
        for (int c = 0; c < NCH; c++) begin
            if (!tbl_busy[c]) continue;
            if (pick == PICK_SAME && tbl_sound[c] != snd) continue;
            if (pick == PICK_LOOP && !tbl_loop[c]) continue;
            age = handle_ctr - tbl_handle[c];
            if (best < 0 || age > best_age) begin
                best     = c;
                best_age = age;
            end
        end
        return best;
    endfunction

    // Apply one command to the shadow table and return the response it causes.
    function automatic vca_pkg::t_vca_rsp predict_rsp(input vca_pkg::t_vca_cmd cmd);
        vca_pkg::t_vca_rsp r;
        int                ch;
        logic [7:0]        snd;
        r   = '0;
        snd = cmd.sound_id & SND_MASK;
        case (cmd.opcode)
            vca_pkg::OP_PLAY: begin
                ch = -1;
                for (int c = 0; c < NCH; c++)
                    if (!tbl_busy[c]) begin
                        ch = c;
                        break;
                    end
                if (ch < 0) begin
                    r.steal_kind = vca_pkg::KIND_SAME;
                    ch = oldest_voice(PICK_SAME, snd);
                    if (ch < 0) begin
                        r.steal_kind = vca_pkg::KIND_LOOPING;
                        ch = oldest_voice(PICK_LOOP, snd);
                    end
                    if (ch < 0) begin
                        r.steal_kind = vca_pkg::KIND_OLDEST;
                        ch = oldest_voice(PICK_ANY, snd);
                    end
                    r.stolen_handle = tbl_handle[ch];
                    clear_chan(ch);
                end
                handle_ctr = handle_ctr + 32'd1;
                if (handle_ctr == '0) handle_ctr = 32'd1;
                tbl_busy[ch]     = 1'b1;
                tbl_handle[ch]   = handle_ctr;
                tbl_sound[ch]    = snd;
                tbl_loop[ch]     = cmd.loop_flag;
                tbl_paused[ch]   = 1'b0;
                r.new_handle     = handle_ctr;
                r.chosen_channel = 3'(ch);
            end
            vca_pkg::OP_STOP: begin
                ch = lookup_handle(cmd.voice_handle);
                if (ch < 0) r.status = vca_pkg::STS_NO_HANDLE;
                else clear_chan(ch);
            end
            vca_pkg::OP_PAUSE: begin
                ch = lookup_handle(cmd.voice_handle);
                if (ch < 0) r.status = vca_pkg::STS_NO_HANDLE;
                else if (tbl_paused[ch]) r.status = vca_pkg::STS_WRONG_STATE;
                else tbl_paused[ch] = 1'b1;
            end
            vca_pkg::OP_RESUME: begin
                ch = lookup_handle(cmd.voice_handle);
                if (ch < 0) r.status = vca_pkg::STS_NO_HANDLE;
                else if (!tbl_paused[ch]) r.status = vca_pkg::STS_WRONG_STATE;
                else tbl_paused[ch] = 1'b0;
            end
            vca_pkg::OP_QUERY: begin
                ch = lookup_handle(cmd.voice_handle);
                if (ch < 0) begin
                    r.status      = vca_pkg::STS_NO_HANDLE;
                    r.voice_state = vca_pkg::VS_STOPPED;
                end else begin
                    r.voice_state = tbl_paused[ch] ? vca_pkg::VS_PAUSED
                                                   : vca_pkg::VS_PLAYING;
                end
            end
            vca_pkg::OP_DONE: begin
                if (int'(cmd.done_channel) < NCH && tbl_busy[cmd.done_channel])
                    clear_chan(int'(cmd.done_channel));
                else
                    r.status = vca_pkg::STS_NO_HANDLE;
            end
            vca_pkg::OP_STOP_ALL: begin
                for (int c = 0; c < NCH; c++) clear_chan(c);
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic vca_pkg::t_vca_cmd mk_cmd(input logic [2:0] op,
                                                 input logic [7:0] snd,
                                                 input logic lp, input logic [31:0] h,
                                                 input logic [2:0] dc);
        vca_pkg::t_vca_cmd c;
        c.opcode       = op;
        c.sound_id     = snd;
        c.loop_flag    = lp;
        c.voice_handle = h;
        c.done_channel = dc;
        return c;
    endfunction

    // Mostly plays and commands on live handles; some misses and noise.
    function automatic vca_pkg::t_vca_cmd rand_cmd();
        vca_pkg::t_vca_cmd c;
        int                live[$];
        int                pick;
        c.sound_id     = 8'($urandom);
        c.loop_flag    = 1'($urandom);
        c.voice_handle = $urandom;
        c.done_channel = 3'($urandom);
        for (int i = 0; i < NCH; i++)
            if (tbl_busy[i]) live.push_back(i);
        pick = $urandom_range(99);
        if (pick < 40) begin
            c.opcode = vca_pkg::OP_PLAY;
            if ($urandom_range(3) != 0) c.sound_id = 8'($urandom_range(5));
        end else if (pick < 75) begin
            c.opcode = 3'($urandom_range(int'(vca_pkg::OP_STOP), int'(vca_pkg::OP_QUERY)));
            if (live.size() != 0)
                c.voice_handle = tbl_handle[live[$urandom_range(live.size() - 1)]];
        end else if (pick < 85) begin
            c.opcode = 3'($urandom_range(int'(vca_pkg::OP_STOP), int'(vca_pkg::OP_QUERY)));
            if ($urandom_range(1) != 0) c.voice_handle = handle_ctr - $urandom_range(20);
        end else if (pick < 95) begin
            c.opcode = vca_pkg::OP_DONE;
        end else if (pick < 98) begin
            c.opcode = vca_pkg::OP_STOP_ALL;
        end else begin
            c.opcode = OP_UNUSED;
        end
        return c;
    endfunction

    // Offer one command beat; idle first at the sender's rate. Return right
    // after the accepting edge with valid still high, so the next call decides.
    task automatic send_cmd(input vca_pkg::t_vca_cmd cmd);
        while ($urandom_range(99) < sender_idle_pct) begin
            cmd_if.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid = 1'b1;
        cmd_if.data  = cmd;
        do @(posedge i_clk); while (!cmd_if.ready);
        pending_rsp.push_back(predict_rsp(cmd));
        @(negedge i_clk);
    endtask

    // Drive ready at the falling edge; a requested hold-off wins over idling.
    always @(negedge i_clk) begin
        if (stall_reqs != stall_seen) begin
            stall_seen = stall_reqs;
            stall_left = STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready = 1'b0;
        end else begin
            rsp_if.ready = ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : rsp_check
        vca_pkg::t_vca_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_rsp.size() == 0) begin
                $error("response beat with no command outstanding");
                errors++;
            end else begin
                want = pending_rsp.pop_front();
                check_field("status", 32'(want.status), 32'(rsp_if.data.status));
                check_field("new_handle", want.new_handle, rsp_if.data.new_handle);
                check_field("chosen_channel", 32'(want.chosen_channel),
                            32'(rsp_if.data.chosen_channel));
                check_field("steal_kind", 32'(want.steal_kind),
                            32'(rsp_if.data.steal_kind));
                check_field("stolen_handle", want.stolen_handle,
                            rsp_if.data.stolen_handle);
                check_field("voice_state", 32'(want.voice_state),
                            32'(rsp_if.data.voice_state));
            end
        end
    end

    // Lookups of handle zero, unknown handles, a free channel and the unused code.
    task automatic test_misses();
        send_cmd(mk_cmd(vca_pkg::OP_QUERY,  8'h00, 1'b0, 32'h0000_0000, 3'd0));
        send_cmd(mk_cmd(vca_pkg::OP_STOP,   8'h00, 1'b0, 32'hFFFF_FFFF, 3'd0));
        send_cmd(mk_cmd(vca_pkg::OP_PAUSE,  8'h00, 1'b0, 32'h1234_5678, 3'd0));
        send_cmd(mk_cmd(vca_pkg::OP_RESUME, 8'h00, 1'b0, 32'h8000_0001, 3'd0));
        send_cmd(mk_cmd(vca_pkg::OP_DONE,   8'h00, 1'b0, 32'h0000_0000, 3'd3));
        send_cmd(mk_cmd(OP_UNUSED,          8'hFF, 1'b1, 32'hFFFF_FFFF, 3'd7));
    endtask

    // Fill every channel with distinct sounds, one looping, then walk pause states.
    task automatic test_fill_and_pause();
        logic [31:0] h;
        for (int c = 0; c < NCH; c++)
            send_cmd(mk_cmd(vca_pkg::OP_PLAY, (c == 1) ? 8'hFF : 8'(c * 16), 1'(c == 5),
                            32'hFFFF_FFFF, 3'd7));
        h = tbl_handle[1];
        send_cmd(mk_cmd(vca_pkg::OP_PAUSE,  8'h00, 1'b0, h, 3'd0));
        send_cmd(mk_cmd(vca_pkg::OP_PAUSE,  8'h00, 1'b0, h, 3'd0));
        send_cmd(mk_cmd(vca_pkg::OP_QUERY,  8'h00, 1'b0, h, 3'd0));
        send_cmd(mk_cmd(vca_pkg::OP_RESUME, 8'h00, 1'b0, h, 3'd0));
        send_cmd(mk_cmd(vca_pkg::OP_RESUME, 8'h00, 1'b0, h, 3'd0));
        send_cmd(mk_cmd(vca_pkg::OP_QUERY,  8'h00, 1'b0, tbl_handle[2], 3'd0));
    endtask

    // Full table: steal a same-sound voice, then the only looper, then the oldest.
    task automatic test_stealing();
        send_cmd(mk_cmd(vca_pkg::OP_PLAY, 8'd32,  1'b0, 32'h0, 3'd0));
        send_cmd(mk_cmd(vca_pkg::OP_PLAY, 8'd200, 1'b0, 32'h0, 3'd0));
        send_cmd(mk_cmd(vca_pkg::OP_PLAY, 8'd201, 1'b0, 32'h0, 3'd0));
    endtask

    task automatic test_release_paths();
        send_cmd(mk_cmd(vca_pkg::OP_DONE,     8'h00, 1'b0, 32'h0,         3'd3));
        send_cmd(mk_cmd(vca_pkg::OP_STOP,     8'h00, 1'b0, tbl_handle[4], 3'd0));
        send_cmd(mk_cmd(vca_pkg::OP_STOP_ALL, 8'h00, 1'b0, 32'h0,         3'd0));
    endtask

    task automatic test_random_traffic(input int count, input int s_pct, input int r_pct);
        sender_idle_pct   = s_pct;
        receiver_idle_pct = r_pct;
        repeat (count) send_cmd(rand_cmd());
    endtask

    // Hold the response side off while commands keep coming, so input stalls.
    task automatic test_full_stall();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        stall_reqs++;
        repeat (30) send_cmd(rand_cmd());
    endtask

    initial begin
        i_rst_n       = 1'b0;
        cmd_if.valid  = 1'b0;
        cmd_if.data   = '0;
        for (int c = 0; c < NCH; c++) clear_chan(c);
        handle_ctr = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_misses();
        test_fill_and_pause();
        test_stealing();
        test_release_paths();
        test_random_traffic(330, 30, 46);
        test_random_traffic(330, 46, 30);
        test_random_traffic(330, 0, 0);
        test_full_stall();

        cmd_if.valid = 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #(TIMEOUT);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
